>>> rtl/cnp_pkg.sv
// Shared types and constants for the Chinese numeral parser.
// Holds code points, status codes, the token passed between stages and the
// x10000 shift-add helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cnp_pkg;

    localparam int VAL_W  = 63;
    localparam int CODE_W = 21;

    localparam logic [VAL_W-1:0] MAX_VAL   = '1;
    localparam logic [VAL_W-1:0] LIM_TEN_K = MAX_VAL / 63'd10000;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // numeral code points
    localparam logic [CODE_W-1:0] CP_ZERO     = 21'h096F6;
    localparam logic [CODE_W-1:0] CP_ONE      = 21'h04E00;
    localparam logic [CODE_W-1:0] CP_TWO      = 21'h04E8C;
    localparam logic [CODE_W-1:0] CP_TWO_ALT  = 21'h04E24;
    localparam logic [CODE_W-1:0] CP_THREE    = 21'h04E09;
    localparam logic [CODE_W-1:0] CP_FOUR     = 21'h056DB;
    localparam logic [CODE_W-1:0] CP_FIVE     = 21'h04E94;
    localparam logic [CODE_W-1:0] CP_SIX      = 21'h0516D;
    localparam logic [CODE_W-1:0] CP_SEVEN    = 21'h04E03;
    localparam logic [CODE_W-1:0] CP_EIGHT    = 21'h0516B;
    localparam logic [CODE_W-1:0] CP_NINE     = 21'h04E5D;
    localparam logic [CODE_W-1:0] CP_TEN      = 21'h05341;
    localparam logic [CODE_W-1:0] CP_HUNDRED  = 21'h0767E;
    localparam logic [CODE_W-1:0] CP_THOUSAND = 21'h05343;
    localparam logic [CODE_W-1:0] CP_TEN_K    = 21'h04E07;
    localparam logic [CODE_W-1:0] CP_HUN_M    = 21'h04EBF;

    typedef enum logic [1:0] {
        BIG_NONE  = 2'd0,
        BIG_TEN_K = 2'd1,
        BIG_HUN_M = 2'd2
    } big_t;

    typedef struct packed {
        logic             hit;
        logic [3:0]       d;
    } digit_t;

    // one token per big unit or per end of string
    typedef struct packed {
        logic             is_end;
        logic             bad;
        logic             ovf;
        big_t             big;
        logic [VAL_W-1:0] val;
    } tok_t;

    function automatic digit_t digit_lookup(input logic [CODE_W-1:0] cp);
        digit_t r;
        r.hit = 1'b1;
        case (cp)
            CP_ZERO:    r.d = 4'd0;
            CP_ONE:     r.d = 4'd1;
            CP_TWO:     r.d = 4'd2;
            CP_TWO_ALT: r.d = 4'd2;
            CP_THREE:   r.d = 4'd3;
            CP_FOUR:    r.d = 4'd4;
            CP_FIVE:    r.d = 4'd5;
            CP_SIX:     r.d = 4'd6;
            CP_SEVEN:   r.d = 4'd7;
            CP_EIGHT:   r.d = 4'd8;
            CP_NINE:    r.d = 4'd9;
            default:
            begin
                r.hit = 1'b0;
                r.d   = 4'd0;
            end
        endcase
        return r;
    endfunction

    // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4, low 63 bits kept
    function automatic logic [VAL_W-1:0] mul_ten_k(input logic [VAL_W-1:0] v);
        return (v << 13) + (v << 10) + (v << 9) + (v << 8) + (v << 4);
    endfunction

endpackage

`default_nettype wire

>>> rtl/chinese_numeral_parser_top.sv
// Chinese numeral parser, top level: front stage, two x10000 stages, total.
// A tlast beat goes through the front token register, m1, m2 and output register.
// Throughput: one beat per cycle unless the output stalls; single register stages.
// Reset: rst_n clears all string state and valid flags asynchronously.
// Depends on cnp_pkg and cnp_front.
`timescale 1ns / 1ps
`default_nettype none

module chinese_numeral_parser_top
    import cnp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [62:0] value, [63] zero pad
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    // Token flow:
    //   front  - decodes the byte, keeps digit/section, emits a token for
    //            each big unit (operand to multiply) and each end of string
    //   m1     - x10000 for both big units, with overflow check
    //   m2     - second x10000 for the hundred-million unit
    //   total  - accumulates products; an end token adds its value and
    //            loads the output register, then clears the total
    // Overflow is tracked as sticky flags; once set, the values that follow
    // in that string no longer matter since the result reads zero.

    tok_t              tok;
    logic              tok_valid;
    logic              tok_ready;

    tok_t              m1_reg, m1_next;
    logic              m1_v_reg;
    tok_t              m2_reg, m2_next;
    logic              m2_v_reg;
    logic              m1_free, m2_free;
    logic              m2_take;

    logic [VAL_W-1:0]  total_reg;
    logic              ovf_reg;
    logic [VAL_W:0]    sum;
    logic              ovf_any;
    logic [1:0]        status_next;

    logic              out_v_reg;
    logic [VAL_W-1:0]  out_val_reg;
    logic [1:0]        out_st_reg;

    cnp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .text_byte (s_axis_tdata),
        .last      (s_axis_tlast),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready)
    );

    // only an end token waits on the output register
    assign m2_free   = !m2_v_reg || !m2_reg.is_end || !out_v_reg || m_axis_tready;
    assign m1_free   = !m1_v_reg || m2_free;
    assign tok_ready = m1_free;
    assign m2_take   = m2_v_reg && m2_free;

    always_comb
    begin
        m1_next = tok;
        if (tok.big != BIG_NONE)
        begin
            m1_next.val = mul_ten_k(tok.val);
            m1_next.ovf = tok.ovf || (tok.val > LIM_TEN_K);
        end
        m2_next = m1_reg;
        if (m1_reg.big == BIG_HUN_M)
        begin
            m2_next.val = mul_ten_k(m1_reg.val);
            m2_next.ovf = m1_reg.ovf || (m1_reg.val > LIM_TEN_K);
        end
    end

    // final accumulate and result select
    always_comb
    begin
        sum     = {1'b0, total_reg} + {1'b0, m2_reg.val};
        ovf_any = ovf_reg || m2_reg.ovf || sum[VAL_W];
        if (m2_reg.bad)
        begin
            status_next = ST_BAD;
        end
        else if (ovf_any)
        begin
            status_next = ST_OVF;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg  <= 1'b0;
            m2_v_reg  <= 1'b0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (m1_free)
            begin
                m1_v_reg <= tok_valid;
            end
            if (m2_free)
            begin
                m2_v_reg <= m1_v_reg;
            end
            if (m2_take)
            begin
                if (m2_reg.is_end)
                begin
                    total_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    total_reg <= sum[VAL_W-1:0];
                    ovf_reg   <= ovf_any;
                end
            end
            if (m2_take && m2_reg.is_end)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m1_free && tok_valid)
        begin
            m1_reg <= m1_next;
        end
        if (m2_free && m1_v_reg)
        begin
            m2_reg <= m2_next;
        end
        if (m2_take && m2_reg.is_end)
        begin
            out_st_reg  <= status_next;
            out_val_reg <= (status_next == ST_OK) ? sum[VAL_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {1'b0, out_val_reg};
    assign m_axis_tuser  = out_st_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // an error status always carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == 64'd0)
    else $error("error result with nonzero value");

    // status is one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_BAD)
                          || (m_axis_tuser == ST_OVF))
    else $error("undefined result status");

    // a front token not taken is held intact
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok))
    else $error("front token lost or changed while stalled");

    // an end token blocked by a full output register stays in place
    assert property (@(posedge clk) disable iff (!rst_n)
        m2_v_reg && m2_reg.is_end && out_v_reg && !m_axis_tready
        |=> m2_v_reg && $stable(m2_reg))
    else $error("end token dropped while output blocked");

    // the running total is clear after a string completes
    assert property (@(posedge clk) disable iff (!rst_n)
        m2_take && m2_reg.is_end |=> total_reg == '0 && !ovf_reg)
    else $error("total not cleared after end of string");

endmodule

`default_nettype wire

>>> rtl/cnp_front.sv
// Front stage: UTF-8 assembly, numeral decode, digit and section tracking.
// Emits a registered token for every big unit and every end of string.
// Depends on cnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cnp_front
    import cnp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       last,
    output tok_t            tok,
    output logic            tok_valid,
    input  wire logic       tok_ready
);

    logic [CODE_W-1:0] code_reg, code_next;
    logic [1:0]        left_reg, left_next;
    logic [3:0]        digit_reg, digit_next;
    logic [VAL_W-1:0]  sect_reg, sect_next;
    logic              bad_reg, bad_next;
    logic              ovf_reg, ovf_next;
    tok_t              tok_reg, tok_next;
    logic              tok_v_reg;

    logic              fire;
    logic              take;
    logic              mark;
    logic [CODE_W-1:0] cp;
    digit_t            dig;
    logic              small_hit;
    logic [9:0]        scale;
    big_t              big_kind;
    big_t              big_now;
    logic              eff;
    logic              small_now;
    logic [13:0]       prod;
    logic [VAL_W-1:0]  add_a, add_b;
    logic [VAL_W:0]    sum;
    logic              emit;

    assign in_ready  = !tok_v_reg || tok_ready;
    assign fire      = in_valid && in_ready;
    assign tok       = tok_reg;
    assign tok_valid = tok_v_reg;

    // character assembly
    always_comb
    begin
        code_next = code_reg;
        left_next = left_reg;
        take      = 1'b0;
        cp        = '0;
        mark      = 1'b0;
        if (left_reg == 2'd0)
        begin
            if ((text_byte & 8'hE0) == 8'hC0)
            begin
                code_next = {16'd0, text_byte[4:0]};
                left_next = 2'd1;
            end
            else if ((text_byte & 8'hF0) == 8'hE0)
            begin
                code_next = {17'd0, text_byte[3:0]};
                left_next = 2'd2;
            end
            else if ((text_byte & 8'hF8) == 8'hF0)
            begin
                code_next = {18'd0, text_byte[2:0]};
                left_next = 2'd3;
            end
            else
            begin
                take = 1'b1;
                cp   = {13'd0, text_byte};
            end
        end
        else
        begin
            // bit 20 flags a malformed continuation byte
            mark      = code_reg[CODE_W-1] || ((text_byte & 8'hC0) != 8'h80);
            code_next = {code_reg[14:0], text_byte[5:0]} | {mark, 20'd0};
            left_next = left_reg - 2'd1;
            take      = (left_reg == 2'd1);
            cp        = code_next;
        end
    end

    // numeral decode and accumulation
    always_comb
    begin
        dig       = digit_lookup(cp);
        small_hit = 1'b1;
        big_kind  = BIG_NONE;
        scale     = 10'd0;
        case (cp)
            CP_TEN:      scale = 10'd10;
            CP_HUNDRED:  scale = 10'd100;
            CP_THOUSAND: scale = 10'd1000;
            CP_TEN_K:
            begin
                small_hit = 1'b0;
                big_kind  = BIG_TEN_K;
            end
            CP_HUN_M:
            begin
                small_hit = 1'b0;
                big_kind  = BIG_HUN_M;
            end
            default:     small_hit = 1'b0;
        endcase

        eff        = take && !bad_reg;
        digit_next = digit_reg;
        bad_next   = bad_reg;
        big_now    = BIG_NONE;
        small_now  = 1'b0;
        if (eff)
        begin
            if (dig.hit)
            begin
                digit_next = dig.d;
            end
            else if (small_hit)
            begin
                digit_next = 4'd0;
                small_now  = 1'b1;
            end
            else if (big_kind != BIG_NONE)
            begin
                digit_next = 4'd0;
                big_now    = big_kind;
            end
            else
            begin
                bad_next = 1'b1;
            end
        end

        prod = 14'((digit_reg == 4'd0) ? 4'd1 : digit_reg) * 14'(scale);

        // one shared adder: section update, big-unit operand, or end sum
        if (small_now)
        begin
            add_a = sect_reg;
            add_b = {{(VAL_W-14){1'b0}}, prod};
        end
        else if (big_now != BIG_NONE)
        begin
            add_a = (sect_reg == '0 && digit_reg == 4'd0) ?
                    {{(VAL_W-1){1'b0}}, 1'b1} : sect_reg;
            add_b = {{(VAL_W-4){1'b0}}, digit_reg};
        end
        else
        begin
            add_a = sect_reg;
            add_b = {{(VAL_W-4){1'b0}}, digit_next};
        end
        sum = {1'b0, add_a} + {1'b0, add_b};

        sect_next = sect_reg;
        ovf_next  = ovf_reg;
        if (small_now)
        begin
            sect_next = sum[VAL_W-1:0];
            ovf_next  = ovf_reg || sum[VAL_W];
        end
        else if (big_now != BIG_NONE)
        begin
            sect_next = '0;
        end

        tok_next.is_end = last;
        tok_next.bad    = bad_next;
        tok_next.ovf    = sum[VAL_W] || (last && ovf_next);
        tok_next.big    = big_now;
        tok_next.val    = sum[VAL_W-1:0];
        emit            = last || (big_now != BIG_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg  <= '0;
            left_reg  <= 2'd0;
            digit_reg <= 4'd0;
            sect_reg  <= '0;
            bad_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            tok_v_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (last)
                begin
                    code_reg  <= '0;
                    left_reg  <= 2'd0;
                    digit_reg <= 4'd0;
                    sect_reg  <= '0;
                    bad_reg   <= 1'b0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    code_reg  <= code_next;
                    left_reg  <= left_next;
                    digit_reg <= digit_next;
                    sect_reg  <= sect_next;
                    bad_reg   <= bad_next;
                    ovf_reg   <= ovf_next;
                end
            end
            if (fire && emit)
            begin
                tok_v_reg <= 1'b1;
            end
            else if (tok_ready)
            begin
                tok_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

`default_nettype wire
